[rtl/tpf_pkg.sv]
// Shared types and constants for the tile pixel fetch with frame hold.
package tpf_pkg;

  // Tile memory geometry: bytes are split into an even and an odd bank
  localparam int unsigned TILE_BYTES = 8192;
  localparam int unsigned TILE_AW    = 13;
  localparam int unsigned TILE_WORDS = TILE_BYTES / 2;

  // Map bases and the signed-mode data base
  localparam logic [TILE_AW-1:0] MAP_LOW     = 13'h1800;
  localparam logic [TILE_AW-1:0] MAP_HIGH    = 13'h1C00;
  localparam logic [TILE_AW-1:0] SIGNED_BASE = 13'h1000;
  localparam logic [TILE_AW-1:0] SIGNED_OFS  = 13'h0800;

  // Control bit positions
  localparam int unsigned CTRL_BG_ON   = 0;
  localparam int unsigned CTRL_BG_MAP  = 3;
  localparam int unsigned CTRL_UNSIGN  = 4;
  localparam int unsigned CTRL_WIN_MAP = 6;

  localparam logic [7:0] WIN_X_OFS = 8'd7;
  localparam logic [7:0] TN_FLIP   = 8'h80;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_RENDER = 3'd1,
    OP_ARM    = 3'd2,
    OP_VBLANK = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    LAYER_BG  = 2'd0,
    LAYER_WIN = 2'd1,
    LAYER_OBJ = 2'd2
  } layer_e;

  localparam logic [1:0] ARM_START = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_DATA,
    ST_VWRITE,
    ST_READ,
    ST_COPY
  } state_e;

endpackage

[rtl/tpf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tile_pixel_fetch_frame_hold.sv]
// Top level: tile fetch renderer with live view frame and held snapshot frame.
// Write, arm and vblank without snapshot complete at accept. Render reads the map when
// a tile is fetched, then both data bytes in one read of the even/odd banks; object or
// blanked pixels are written directly. Read data is registered in the frame memories and
// then in the output register once it is free. Snapshot vblank copies view into held.
// After reset max(SCREEN_W*SCREEN_H, 4096) addresses of tile and view RAM are zeroed.
module tile_pixel_fetch_frame_hold #(
  parameter int unsigned SCREEN_W = 160,
  parameter int unsigned SCREEN_H = 144
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [12:0] mem_addr_i,
  input  logic [7:0] mem_data_i,
  input  logic [7:0] col_i,
  input  logic [7:0] line_no_i,
  input  logic [1:0] pixel_layer_i,
  input  logic [7:0] obj_value_i,
  input  logic [7:0] lcd_ctrl_i,
  input  logic [7:0] scroll_x_i,
  input  logic [7:0] scroll_y_i,
  input  logic [7:0] win_x_i,
  input  logic [7:0] win_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] pixel_out_o
);

  localparam int unsigned FRAME_SIZE = SCREEN_W * SCREEN_H;
  localparam int unsigned FA_W       = $clog2(FRAME_SIZE);
  localparam int unsigned FC_W       = $clog2(FRAME_SIZE + 1);
  localparam int unsigned TW_W       = $clog2(tpf_pkg::TILE_WORDS);
  localparam int unsigned CLR_N      = (FRAME_SIZE > tpf_pkg::TILE_WORDS) ?
                                       FRAME_SIZE : tpf_pkg::TILE_WORDS;
  localparam int unsigned CLR_W      = $clog2(CLR_N);

  localparam logic [FA_W-1:0]  W_C       = FA_W'(SCREEN_W);
  localparam logic [8:0]       W_CMP     = 9'(SCREEN_W);
  localparam logic [8:0]       H_CMP     = 9'(SCREEN_H);
  localparam logic [FC_W-1:0]  FRAME_END = FC_W'(FRAME_SIZE);
  localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_N - 1);

  tpf_pkg::state_e state_q, state_d;

  // Control registers
  logic [1:0]       arm_q, arm_d;
  logic             hold_q, hold_d;
  logic [CLR_W-1:0] clr_q, clr_d;
  logic [FC_W-1:0]  cp_q, cp_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers
  logic [FA_W-1:0]  cp_waddr_q, cp_waddr_d;
  logic [FA_W-1:0]  vaddr_q, vaddr_d;
  logic [7:0]       pix_q, pix_d;
  logic [2:0]       px_lo_q, px_lo_d;
  logic [2:0]       py_lo_q, py_lo_d;
  logic             unsign_q, unsign_d;
  logic             map_odd_q, map_odd_d;
  logic             sel_held_q, sel_held_d;
  logic             rd_zero_q, rd_zero_d;
  logic [7:0]       pixel_q, pixel_d;

  // Memory ports
  logic            te_we, to_we, t_re;
  logic [TW_W-1:0] t_waddr, t_raddr;
  logic [7:0]      t_wdata, te_rdata, to_rdata;
  logic            v_we, v_re, h_we, h_re;
  logic [FA_W-1:0] v_waddr, v_raddr, h_waddr, h_raddr;
  logic [7:0]      v_wdata, v_rdata, h_wdata, h_rdata;

  // Accept-time decode
  logic                         accept;
  logic                         on_screen, x_in, y_in, is_win, direct, map_sel;
  logic [7:0]                   px, py, row;
  logic [tpf_pkg::TILE_AW-1:0]  map_addr, data_addr;
  logic [FA_W-1:0]              frame_addr;
  logic [7:0]                   tn;

  assign accept     = in_valid_i && in_ready_o;
  assign x_in       = {1'b0, col_i} < W_CMP;
  assign y_in       = {1'b0, line_no_i} < H_CMP;
  assign on_screen  = x_in && y_in;
  assign is_win     = pixel_layer_i == tpf_pkg::LAYER_WIN;
  assign direct     = (pixel_layer_i == tpf_pkg::LAYER_OBJ) ||
                      !lcd_ctrl_i[tpf_pkg::CTRL_BG_ON];
  assign px         = is_win ? (col_i + tpf_pkg::WIN_X_OFS - win_x_i) : (col_i + scroll_x_i);
  assign py         = is_win ? win_line_i : (line_no_i + scroll_y_i);
  assign map_sel    = is_win ? lcd_ctrl_i[tpf_pkg::CTRL_WIN_MAP]
                             : lcd_ctrl_i[tpf_pkg::CTRL_BG_MAP];
  assign map_addr   = (map_sel ? tpf_pkg::MAP_HIGH : tpf_pkg::MAP_LOW) |
                      {3'b000, py[7:3], px[7:3]};
  // Reads below the screen fall back to the top line
  assign row        = y_in ? line_no_i : 8'd0;
  assign frame_addr = FA_W'(row) * W_C + FA_W'(col_i);

  // Tile number from the map read, then the even data address
  assign tn        = map_odd_q ? to_rdata : te_rdata;
  assign data_addr = unsign_q ? {1'b0, tn, py_lo_q, 1'b0}
                              : (tpf_pkg::SIGNED_OFS + {1'b0, tn ^ tpf_pkg::TN_FLIP, 4'b0000}
                                 + {9'd0, py_lo_q, 1'b0});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpf_pkg::ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = tpf_pkg::ST_IDLE;
      end
      tpf_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op_i)
            tpf_pkg::OP_RENDER: begin
              if (on_screen) state_d = direct ? tpf_pkg::ST_VWRITE : tpf_pkg::ST_MAP;
            end
            tpf_pkg::OP_VBLANK: begin
              if (arm_q == 2'd1) state_d = tpf_pkg::ST_COPY;
            end
            tpf_pkg::OP_READ: state_d = tpf_pkg::ST_READ;
            default: state_d = tpf_pkg::ST_IDLE;
          endcase
        end
      end
      tpf_pkg::ST_MAP:    state_d = tpf_pkg::ST_DATA;
      tpf_pkg::ST_DATA:   state_d = tpf_pkg::ST_IDLE;
      tpf_pkg::ST_VWRITE: state_d = tpf_pkg::ST_IDLE;
      tpf_pkg::ST_READ: begin
        if (!out_valid_q || out_ready_i) state_d = tpf_pkg::ST_IDLE;
      end
      tpf_pkg::ST_COPY: begin
        if (cp_q == FRAME_END) state_d = tpf_pkg::ST_IDLE;
      end
      default: state_d = tpf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    arm_d       = arm_q;
    hold_d      = hold_q;
    clr_d       = clr_q;
    cp_d        = cp_q;
    pend_d      = pend_q;
    cp_waddr_d  = cp_waddr_q;
    vaddr_d     = vaddr_q;
    pix_d       = pix_q;
    px_lo_d     = px_lo_q;
    py_lo_d     = py_lo_q;
    unsign_d    = unsign_q;
    map_odd_d   = map_odd_q;
    sel_held_d  = sel_held_q;
    rd_zero_d   = rd_zero_q;
    pixel_d     = pixel_q;
    out_valid_d = out_valid_q && !out_ready_i;

    te_we   = 1'b0;
    to_we   = 1'b0;
    t_waddr = mem_addr_i[12:1];
    t_wdata = mem_data_i;
    t_re    = 1'b0;
    t_raddr = map_addr[12:1];
    v_we    = 1'b0;
    v_waddr = vaddr_q;
    v_wdata = pix_q;
    v_re    = 1'b0;
    v_raddr = frame_addr;
    h_we    = 1'b0;
    h_waddr = cp_waddr_q;
    h_wdata = v_rdata;
    h_re    = 1'b0;
    h_raddr = frame_addr;

    unique case (state_q)
      tpf_pkg::ST_CLEAR: begin
        te_we   = 1'b1;
        to_we   = 1'b1;
        t_waddr = clr_q[TW_W-1:0];
        t_wdata = 8'd0;
        v_we    = 1'b1;
        v_waddr = clr_q[FA_W-1:0];
        v_wdata = 8'd0;
        clr_d   = clr_q + CLR_W'(1);
      end
      tpf_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op_i)
            tpf_pkg::OP_WRITE: begin
              te_we = !mem_addr_i[0];
              to_we = mem_addr_i[0];
            end
            tpf_pkg::OP_RENDER: begin
              vaddr_d   = frame_addr;
              pix_d     = (pixel_layer_i == tpf_pkg::LAYER_OBJ) ? obj_value_i : 8'd0;
              px_lo_d   = px[2:0];
              py_lo_d   = py[2:0];
              unsign_d  = lcd_ctrl_i[tpf_pkg::CTRL_UNSIGN];
              map_odd_d = map_addr[0];
              t_re      = on_screen && !direct;
            end
            tpf_pkg::OP_ARM: arm_d = tpf_pkg::ARM_START;
            tpf_pkg::OP_VBLANK: begin
              if (arm_q != 2'd0) begin
                arm_d = arm_q - 2'd1;
                if (arm_q == 2'd1) begin
                  hold_d = 1'b1;
                  cp_d   = '0;
                  pend_d = 1'b0;
                end
              end else begin
                hold_d = 1'b0;
              end
            end
            tpf_pkg::OP_READ: begin
              v_re       = 1'b1;
              h_re       = 1'b1;
              sel_held_d = hold_q;
              rd_zero_d  = !x_in;
            end
            default: ;
          endcase
        end
      end
      tpf_pkg::ST_MAP: begin
        t_re    = 1'b1;
        t_raddr = data_addr[12:1];
      end
      tpf_pkg::ST_DATA: begin
        // Even bank holds the low plane byte, odd bank the high plane byte
        v_we    = 1'b1;
        v_wdata = {6'd0, to_rdata[~px_lo_q], te_rdata[~px_lo_q]};
      end
      tpf_pkg::ST_VWRITE: v_we = 1'b1;
      tpf_pkg::ST_READ: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          pixel_d     = rd_zero_q ? 8'd0 : (sel_held_q ? h_rdata : v_rdata);
        end
      end
      tpf_pkg::ST_COPY: begin
        // Read view at cp, write held in the following cycle
        h_we = pend_q;
        if (cp_q != FRAME_END) begin
          v_re       = 1'b1;
          v_raddr    = cp_q[FA_W-1:0];
          cp_d       = cp_q + FC_W'(1);
          cp_waddr_d = cp_q[FA_W-1:0];
          pend_d     = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpf_pkg::ST_CLEAR;
      arm_q       <= 2'd0;
      hold_q      <= 1'b0;
      clr_q       <= '0;
      cp_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      arm_q       <= arm_d;
      hold_q      <= hold_d;
      clr_q       <= clr_d;
      cp_q        <= cp_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_waddr_q <= cp_waddr_d;
    vaddr_q    <= vaddr_d;
    pix_q      <= pix_d;
    px_lo_q    <= px_lo_d;
    py_lo_q    <= py_lo_d;
    unsign_q   <= unsign_d;
    map_odd_q  <= map_odd_d;
    sel_held_q <= sel_held_d;
    rd_zero_q  <= rd_zero_d;
    pixel_q    <= pixel_d;
  end

  // Tile memory, even and odd byte banks
  tpf_ram #(.WIDTH(8), .DEPTH(tpf_pkg::TILE_WORDS)) u_tile_even (
    .clk_i   (clk_i),
    .we_i    (te_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (te_rdata)
  );

  tpf_ram #(.WIDTH(8), .DEPTH(tpf_pkg::TILE_WORDS)) u_tile_odd (
    .clk_i   (clk_i),
    .we_i    (to_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (to_rdata)
  );

  // Live view frame
  tpf_ram #(.WIDTH(8), .DEPTH(FRAME_SIZE)) u_view (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  // Held snapshot frame
  tpf_ram #(.WIDTH(8), .DEPTH(FRAME_SIZE)) u_held (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  assign in_ready_o  = state_q == tpf_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;

endmodule
